### src/gmlc_pkg.sv
package gmlc_pkg;

    localparam int MAX_BANDS = 4;
    localparam int ENTRIES   = 22;

    localparam logic [4:0] E_OFFSET = 5'd20;
    localparam logic [4:0] E_ID     = 5'd21;

    localparam logic signed [63:0] SMAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SMAX_W = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SMIN_W = -SMAX_W;

    localparam logic [39:0] LIMIT_ALL = 40'hFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [2:0] REG_BANDS        = 3'd0;
    localparam logic [2:0] REG_CLASSES      = 3'd1;
    localparam logic [2:0] REG_LIMIT        = 3'd2;
    localparam logic [2:0] REG_NODATA_EN    = 3'd3;
    localparam logic [2:0] REG_NODATA_VALUE = 3'd4;
    localparam logic [2:0] REG_NOCLASS_CODE = 3'd5;
    localparam logic [2:0] REG_NODATA_CODE  = 3'd6;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [1:0] ST_CLASSIFIED = 2'd0;
    localparam logic [1:0] ST_NOCLASS    = 2'd1;
    localparam logic [1:0] ST_NODATA     = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         table_class;
        logic [4:0]         table_entry;
        logic signed [31:0] table_value;
        logic [15:0]        band_0;
        logic [15:0]        band_1;
        logic [15:0]        band_2;
        logic [15:0]        band_3;
    } in_item_t;

    typedef struct packed {
        logic [15:0] class_code;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic        we;
        logic [4:0]  entry;
        logic [31:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic        start;
        logic [2:0]  nb;
        logic [39:0] limit;
    } lane_cmd_t;

    typedef struct packed {
        logic               done;
        logic               qual;
        logic signed [63:0] score;
        logic [15:0]        id;
    } lane_res_t;

    // symmetric saturating add
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > SMAX_W)
            sat_add = SMAX;
        else if (s < SMIN_W)
            sat_add = -SMAX;
        else
            sat_add = s[63:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        logic signed [63:0] n;
        n = -a;
        mag64 = a[63] ? n : a;
    endfunction

endpackage

### src/gmlc_div.sv
module gmlc_div
    import gmlc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic signed [63:0] q
);

    localparam int NUM_BITS = 79;
    localparam logic [6:0] STEPS = 7'(NUM_BITS);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_RUN  = 2'd1;
    localparam logic [1:0] DV_FIN  = 2'd2;

    logic [1:0]          st_reg;
    logic [6:0]          cnt_reg;
    logic                done_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [31:0]         rem_reg;
    logic [31:0]         bm_reg;
    logic                neg_reg;
    logic signed [63:0]  q_reg;

    logic [63:0]        am;
    logic signed [32:0] bext;
    logic signed [32:0] bneg;
    logic [32:0]        trial;
    logic               qbit;
    logic [63:0]        qmag;

    assign am    = mag64(a);
    assign bext  = 33'(b);
    assign bneg  = -bext;
    assign trial = {rem_reg, num_reg[NUM_BITS-1]};
    assign qbit  = trial >= {1'b0, bm_reg};
    assign qmag  = (|num_reg[NUM_BITS-1:63]) ? SMAX : {1'b0, num_reg[62:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= DV_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        if (b == '0)
                            done_reg <= 1'b1;
                        else
                        begin
                            st_reg  <= DV_RUN;
                            cnt_reg <= STEPS;
                        end
                    end
                end
                DV_RUN:
                begin
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                        st_reg <= DV_FIN;
                end
                DV_FIN:
                begin
                    done_reg <= 1'b1;
                    st_reg   <= DV_IDLE;
                end
                default:
                    st_reg <= DV_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == DV_IDLE && start)
        begin
            num_reg <= {am[62:0], 16'h0000};
            rem_reg <= '0;
            bm_reg  <= b[31] ? bneg[31:0] : bext[31:0];
            neg_reg <= a[63] ^ b[31];
            // zero divisor: saturate to the sign of the dividend
            if (a[63])
                q_reg <= -SMAX;
            else if (a != '0)
                q_reg <= SMAX;
            else
                q_reg <= '0;
        end
        else if (st_reg == DV_RUN)
        begin
            rem_reg <= qbit ? 32'(trial - {1'b0, bm_reg}) : trial[31:0];
            num_reg <= {num_reg[NUM_BITS-2:0], qbit};
        end
        else if (st_reg == DV_FIN)
        begin
            q_reg <= neg_reg ? -$signed(qmag) : $signed(qmag);
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

### src/gmlc_lane.sv
module gmlc_lane
    import gmlc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lane_cmd_t                    cmd,
    input  logic [MAX_BANDS-1:0][15:0]   samples,
    input  tbl_wr_t                      wr,
    output lane_res_t                    res
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_READ = 3'd1;
    localparam logic [2:0] L_EXEC = 3'd2;
    localparam logic [2:0] L_MUL  = 3'd3;
    localparam logic [2:0] L_ACC  = 3'd4;
    localparam logic [2:0] L_DIV  = 3'd5;
    localparam logic [2:0] L_DONE = 3'd6;

    localparam logic [2:0] P_DIFF = 3'd0;
    localparam logic [2:0] P_FWD  = 3'd1;
    localparam logic [2:0] P_BACK = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_TERM = 3'd4;
    localparam logic [2:0] P_OFS  = 3'd5;
    localparam logic [2:0] P_ID   = 3'd6;

    // class table of this lane
    logic [31:0]        mem [ENTRIES];
    logic signed [31:0] rd_reg;
    logic [4:0]         raddr;

    logic [2:0] st_reg;
    logic [2:0] ph_reg;
    logic [1:0] i_reg;
    logic [1:0] j_reg;
    logic [2:0] mk_reg;

    logic [2:0] ph_next;
    logic [1:0] i_next;
    logic [1:0] j_next;
    logic [1:0] nbm1;

    logic signed [33:0] d_reg [MAX_BANDS];
    logic signed [63:0] w_reg [MAX_BANDS];
    logic signed [63:0] term_reg;
    logic signed [63:0] score_reg;
    logic               qual_reg;
    logic [15:0]        id_reg;

    logic [63:0]  am_reg;
    logic [63:0]  bm_reg;
    logic         mneg_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   psh_reg;
    logic [127:0] acc_reg;

    logic signed [63:0] op_a;
    logic signed [63:0] op_b;
    logic [31:0]        a_part;
    logic [31:0]        b_part;
    logic [63:0]        pp_w;
    logic [63:0]        mres;
    logic signed [63:0] prod;
    logic signed [33:0] dv;
    logic signed [63:0] tplus;
    logic signed [63:0] half;
    logic signed [63:0] score_new;
    logic               qual_new;

    logic               div_start;
    logic               div_done;
    logic signed [63:0] div_q;

    assign nbm1 = 2'(cmd.nb - 3'd1);

    always_comb
    begin
        unique case (ph_reg)
            P_DIFF:           raddr = {3'b000, i_reg};
            P_FWD, P_BACK:    raddr = 5'd4 + {1'b0, i_reg, j_reg};
            P_DIV:            raddr = 5'd4 + {1'b0, i_reg, i_reg};
            P_OFS:            raddr = E_OFFSET;
            P_ID:             raddr = E_ID;
            default:          raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
            mem[wr.entry] <= wr.data;
        rd_reg <= mem[raddr];
    end

    // order of the solve steps
    always_comb
    begin
        ph_next = ph_reg;
        i_next  = i_reg;
        j_next  = j_reg;
        unique case (ph_reg)
            P_DIFF:
            begin
                if (i_reg != nbm1)
                    i_next = i_reg + 2'd1;
                else if (nbm1 != 2'd0)
                begin
                    ph_next = P_FWD;
                    i_next  = 2'd1;
                    j_next  = 2'd0;
                end
                else
                begin
                    ph_next = P_DIV;
                    i_next  = nbm1;
                end
            end
            P_FWD:
            begin
                if (j_reg != i_reg - 2'd1)
                    j_next = j_reg + 2'd1;
                else if (i_reg != nbm1)
                begin
                    i_next = i_reg + 2'd1;
                    j_next = 2'd0;
                end
                else
                begin
                    ph_next = P_DIV;
                    i_next  = nbm1;
                end
            end
            P_DIV:
            begin
                if (i_reg == 2'd0)
                    ph_next = P_TERM;
                else
                begin
                    ph_next = P_BACK;
                    i_next  = i_reg - 2'd1;
                    j_next  = nbm1;
                end
            end
            P_BACK:
            begin
                if (j_reg != i_reg + 2'd1)
                    j_next = j_reg - 2'd1;
                else
                    ph_next = P_DIV;
            end
            P_TERM:
            begin
                if (i_reg != nbm1)
                    i_next = i_reg + 2'd1;
                else
                    ph_next = P_OFS;
            end
            P_OFS:
                ph_next = P_ID;
            default:
                ph_next = P_ID;
        endcase
    end

    assign op_a = (ph_reg == P_TERM) ? w_reg[i_reg] : w_reg[j_reg];
    assign op_b = (ph_reg == P_TERM) ? 64'(d_reg[i_reg]) : 64'(rd_reg);

    assign a_part = mk_reg[0] ? am_reg[63:32] : am_reg[31:0];
    assign b_part = mk_reg[1] ? bm_reg[63:32] : bm_reg[31:0];
    assign pp_w   = a_part * b_part;

    // both high words nonzero saturates outright
    assign mres = ((|am_reg[63:32]) && (|bm_reg[63:32])) || (|acc_reg[127:79])
                  ? SMAX : {1'b0, acc_reg[78:16]};
    assign prod = mneg_reg ? -$signed(mres) : $signed(mres);

    assign dv = $signed({2'b00, samples[i_reg], 16'h0000}) - 34'(rd_reg);

    // term halved toward zero
    assign tplus     = term_reg + $signed({63'b0, term_reg[63]});
    assign half      = tplus >>> 1;
    assign score_new = sat_add(64'(rd_reg), -half);
    assign qual_new  = (cmd.limit == LIMIT_ALL) || (term_reg < $signed({24'b0, cmd.limit}));

    assign div_start = (st_reg == L_EXEC) && (ph_reg == P_DIV);

    gmlc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (w_reg[i_reg]),
        .b     (rd_reg),
        .done  (div_done),
        .q     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= L_IDLE;
            ph_reg <= P_DIFF;
            i_reg  <= '0;
            j_reg  <= '0;
            mk_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                L_IDLE, L_DONE:
                begin
                    if (cmd.start)
                    begin
                        st_reg <= L_READ;
                        ph_reg <= P_DIFF;
                        i_reg  <= '0;
                        j_reg  <= '0;
                    end
                end
                L_READ:
                    st_reg <= L_EXEC;
                L_EXEC:
                begin
                    unique case (ph_reg)
                        P_DIFF, P_OFS:
                        begin
                            st_reg <= L_READ;
                            ph_reg <= ph_next;
                            i_reg  <= i_next;
                            j_reg  <= j_next;
                        end
                        P_DIV:
                            st_reg <= L_DIV;
                        P_ID:
                            st_reg <= L_DONE;
                        default:
                        begin
                            st_reg <= L_MUL;
                            mk_reg <= '0;
                        end
                    endcase
                end
                L_MUL:
                begin
                    mk_reg <= mk_reg + 3'd1;
                    if (mk_reg == 3'd4)
                        st_reg <= L_ACC;
                end
                L_ACC, L_DIV:
                begin
                    if (st_reg == L_ACC || div_done)
                    begin
                        st_reg <= L_READ;
                        ph_reg <= ph_next;
                        i_reg  <= i_next;
                        j_reg  <= j_next;
                    end
                end
                default:
                    st_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((st_reg == L_IDLE || st_reg == L_DONE) && cmd.start)
            term_reg <= '0;

        if (st_reg == L_EXEC)
        begin
            if (ph_reg == P_DIFF)
            begin
                d_reg[i_reg] <= dv;
                w_reg[i_reg] <= 64'(dv);
            end
            if (ph_reg == P_FWD || ph_reg == P_BACK || ph_reg == P_TERM)
            begin
                am_reg   <= mag64(op_a);
                bm_reg   <= mag64(op_b);
                mneg_reg <= op_a[63] ^ op_b[63];
                acc_reg  <= '0;
            end
            if (ph_reg == P_OFS)
            begin
                score_reg <= score_new;
                qual_reg  <= qual_new;
            end
            if (ph_reg == P_ID)
                id_reg <= rd_reg[15:0];
        end

        // four 32x32 partial products, one per cycle
        if (st_reg == L_MUL)
        begin
            if (mk_reg != 3'd4)
            begin
                pp_reg  <= pp_w;
                psh_reg <= 2'(mk_reg[0]) + 2'(mk_reg[1]);
            end
            if (mk_reg != 3'd0)
                acc_reg <= acc_reg + (128'(pp_reg) << {psh_reg, 5'b00000});
        end

        if (st_reg == L_ACC)
        begin
            if (ph_reg == P_TERM)
                term_reg <= sat_add(term_reg, prod);
            else
                w_reg[i_reg] <= sat_add(w_reg[i_reg], -prod);
        end

        if (st_reg == L_DIV && div_done)
            w_reg[i_reg] <= div_q;
    end

    assign res.done  = (st_reg == L_DONE);
    assign res.qual  = qual_reg;
    assign res.score = score_reg;
    assign res.id    = id_reg;

endmodule

### src/gaussian_max_likelihood_classifier.sv
// gaussian maximum-likelihood classifier for multiband pixels
//
// input channel (in_valid / in_ready / in_data): each transfer is either a
// table load (cmd load) that writes one word of one class slot, or a pixel
// to classify. loads give no result; every pixel gives exactly one result.
// output channel (out_valid / out_ready / out_data): class id with status
// classified, the no-class code, or the nodata code.
// configuration: cfg_write with cfg_index and cfg_data, to be taken only while
// idle; the user must keep to this, since the block itself never checks it.
// one lane per class slot; all lanes solve L then U side by side, and a
// merge pass then walks the lanes in slot order (lower slot wins ties).
// a pixel's time is set mostly by the bit-serial divisions of the back solve,
// one per band, plus the multiplies and the merge pass over the lanes. a load
// leaves the block idle, and a nodata pixel goes straight to the output and
// skips the lanes. one item is in work at a time.
//
// reset clears the control state and the registers to their defaults; the
// class table holds garbage until loaded. a stalled receiver holds the
// result in the output register; the next item is still accepted, and its
// result waits until the register frees.
module gaussian_max_likelihood_classifier
    import gmlc_pkg::*;
#(
    parameter int BANDS       = 4,
    parameter int CLASSES     = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    // only sixteen slots can be addressed by a load
    localparam int NLANES = (CLASSES > 16) ? 16 : CLASSES;
    localparam int LW     = (NLANES > 1) ? $clog2(NLANES) : 1;

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_START = 3'd1;
    localparam logic [2:0] T_WAIT  = 3'd2;
    localparam logic [2:0] T_MERGE = 3'd3;
    localparam logic [2:0] T_OUT   = 3'd4;

    // configuration registers
    logic [2:0]  bands_reg;
    logic [4:0]  classes_reg;
    logic [39:0] limit_reg;
    logic        nodata_en_reg;
    logic [15:0] nodata_value_reg;
    logic [15:0] noclass_code_reg;
    logic [15:0] nodata_code_reg;

    logic [2:0]  st_reg;
    logic [2:0]  st_next;
    logic [LW:0] kc_reg;
    logic        found_reg;
    logic signed [63:0] best_reg;
    logic [15:0] best_id_reg;
    logic [2:0]  nb_reg;
    logic [6:0]  nc_reg;
    logic [MAX_BANDS-1:0][15:0] samp_reg;
    out_item_t   res_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic                       acc_in;
    logic [2:0]                 nb_w;
    logic [6:0]                 nc_w;
    logic [MAX_BANDS-1:0][15:0] band_w;
    logic [MAX_BANDS-1:0][15:0] samp_w;
    logic                       nodata_w;
    logic                       out_free;
    logic [NLANES-1:0]          done_vec;
    lane_res_t                  lane_res [NLANES];
    lane_res_t                  cur;
    lane_cmd_t                  lane_cmd;
    logic                       take;

    assign in_ready = (st_reg == T_IDLE);
    assign acc_in   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (bands_reg == 3'd0)
            nb_w = 3'd1;
        else if (32'(bands_reg) > BANDS)
            nb_w = 3'(BANDS);
        else
            nb_w = bands_reg;
        nc_w = (7'(classes_reg) > 7'(CLASSES)) ? 7'(CLASSES) : 7'(classes_reg);
    end

    assign band_w = {in_data.band_3, in_data.band_2, in_data.band_1, in_data.band_0};

    // low sample bits only, compared against the nodata value for bands in use
    always_comb
    begin
        nodata_w = 1'b1;
        for (int i = 0; i < MAX_BANDS; i++)
        begin
            samp_w[i] = 16'(band_w[i][SAMPLE_BITS-1:0]);
            if (3'(i) < nb_w && samp_w[i] != nodata_value_reg)
                nodata_w = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bands_reg        <= 3'd4;
            classes_reg      <= 5'd1;
            limit_reg        <= LIMIT_ALL;
            nodata_en_reg    <= 1'b0;
            nodata_value_reg <= '0;
            noclass_code_reg <= '0;
            nodata_code_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BANDS:        bands_reg        <= cfg_data[2:0];
                REG_CLASSES:      classes_reg      <= cfg_data[4:0];
                REG_LIMIT:        limit_reg        <= cfg_data;
                REG_NODATA_EN:    nodata_en_reg    <= cfg_data[0];
                REG_NODATA_VALUE: nodata_value_reg <= cfg_data[15:0];
                REG_NOCLASS_CODE: noclass_code_reg <= cfg_data[15:0];
                REG_NODATA_CODE:  nodata_code_reg  <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // lanes
    assign lane_cmd.start = (st_reg == T_START);
    assign lane_cmd.nb    = nb_reg;
    assign lane_cmd.limit = limit_reg;

    for (genvar k = 0; k < NLANES; k++)
    begin : g_lane
        tbl_wr_t wr;
        assign wr.we    = acc_in && (in_data.cmd == CMD_LOAD)
                          && (32'(in_data.table_class) == k)
                          && (32'(in_data.table_entry) < ENTRIES);
        assign wr.entry = in_data.table_entry;
        assign wr.data  = in_data.table_value;

        gmlc_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (lane_cmd),
            .samples (samp_reg),
            .wr      (wr),
            .res     (lane_res[k])
        );
        assign done_vec[k] = lane_res[k].done;
    end

    // merge: one lane per cycle in slot order
    assign cur  = lane_res[kc_reg[LW-1:0]];
    assign take = (7'(kc_reg) < nc_reg) && cur.qual && (!found_reg || cur.score > best_reg);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            T_IDLE:
            begin
                if (acc_in && in_data.cmd == CMD_CLASSIFY)
                    st_next = (nodata_en_reg && nodata_w) ? T_OUT : T_START;
            end
            T_START:
                st_next = T_WAIT;
            T_WAIT:
            begin
                if (&done_vec)
                    st_next = T_MERGE;
            end
            T_MERGE:
            begin
                if (32'(kc_reg) == NLANES)
                    st_next = T_OUT;
            end
            T_OUT:
            begin
                if (out_free)
                    st_next = T_IDLE;
            end
            default:
                st_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= T_IDLE;
            out_valid_reg <= 1'b0;
            kc_reg        <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == T_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (st_reg == T_WAIT)
            begin
                kc_reg    <= '0;
                found_reg <= 1'b0;
            end
            else if (st_reg == T_MERGE && 32'(kc_reg) != NLANES)
            begin
                kc_reg <= kc_reg + 1'b1;
                if (take)
                    found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_in && in_data.cmd == CMD_CLASSIFY)
        begin
            samp_reg           <= samp_w;
            nb_reg             <= nb_w;
            nc_reg             <= nc_w;
            res_reg.class_code <= nodata_code_reg;
            res_reg.status     <= ST_NODATA;
        end

        if (st_reg == T_MERGE)
        begin
            if (32'(kc_reg) != NLANES)
            begin
                if (take)
                begin
                    best_reg    <= cur.score;
                    best_id_reg <= cur.id;
                end
            end
            else if (found_reg)
            begin
                res_reg.class_code <= best_id_reg;
                res_reg.status     <= ST_CLASSIFIED;
            end
            else
            begin
                res_reg.class_code <= noclass_code_reg;
                res_reg.status     <= ST_NOCLASS;
            end
        end

        if (st_reg == T_OUT && out_free)
            out_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### tb/gaussian_max_likelihood_classifier_tb.sv
module gaussian_max_likelihood_classifier_tb;
    import gmlc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCLS = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [39:0] cfg_data = '0;

    // predictor copy of the class table and the registers
    logic signed [31:0] class_words [NCLS][ENTRIES];
    logic [2:0]  bands_reg;
    logic [4:0]  classes_reg;
    logic [39:0] limit_reg;
    logic        nodata_en_reg;
    logic [15:0] nodata_val_reg, noclass_reg, nodata_code_reg;

    out_item_t expected_codes [$];
    int  error_count = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  rx_hold = 0;
    int  rx_gap = 0;

    gaussian_max_likelihood_classifier u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------- fixed-point arithmetic of the predictor ----------------
    function automatic logic signed [63:0] clamp_mag(logic [63:0] m, bit neg);
        logic signed [63:0] r;
        r = (m > 64'h7FFF_FFFF_FFFF_FFFF) ? SMAX : $signed(m);
        return neg ? -r : r;
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SMAX;
        if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return -SMAX;
        return s[63:0];
    endfunction

    // Q16.16 product truncated toward zero, saturating
    function automatic logic signed [63:0] mul_q16(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [127:0] p;
        logic [63:0]  am, bm;
        bit neg;
        neg = (a < 0) != (b < 0);
        am = abs64(a);
        bm = abs64(b);
        // both high words nonzero saturates outright
        if (am[63:32] != 32'd0 && bm[63:32] != 32'd0) return neg ? -SMAX : SMAX;
        p = 128'(am) * 128'(bm);
        p = p >> 16;
        if (p > 128'h7FFF_FFFF_FFFF_FFFF) return neg ? -SMAX : SMAX;
        return clamp_mag(p[63:0], neg);
    endfunction

    // Q16.16 quotient; zero divisor saturates to the dividend's sign
    function automatic logic signed [63:0] div_q16(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [63:0] am, bm, q, r;
        bit neg;
        if (b == 0) return (a > 0) ? SMAX : ((a < 0) ? -SMAX : 64'sd0);
        neg = (a < 0) != (b < 0);
        am = abs64(a);
        bm = abs64(b);
        q = am / bm;
        r = am % bm;
        if (q >= 64'h8000_0000_0000) return neg ? -SMAX : SMAX;
        return clamp_mag((q << 16) + 64'((128'(r) << 16) / 128'(bm)), neg);
    endfunction

    // expected result of one pixel under the current registers and table
    function automatic out_item_t classify_pixel(in_item_t px);
        logic [15:0] smp [4];
        logic signed [63:0] dif [4], fwd [4], sol [4];
        logic signed [63:0] term, score, best;
        int nb, nc;
        bit found, all_nodata;
        out_item_t res;
        nb = (bands_reg < 1) ? 1 : ((bands_reg > 4) ? 4 : int'(bands_reg));
        nc = (classes_reg > NCLS) ? NCLS : int'(classes_reg);
        smp[0] = px.band_0; smp[1] = px.band_1;
        smp[2] = px.band_2; smp[3] = px.band_3;
        all_nodata = 1'b1;
        for (int i = 0; i < nb; i++)
            if (smp[i] != nodata_val_reg) all_nodata = 1'b0;
        if (nodata_en_reg && all_nodata)
        begin
            res.class_code = nodata_code_reg;
            res.status = ST_NODATA;
            return res;
        end
        found = 1'b0;
        best = '0;
        res = '0;
        for (int c = 0; c < nc; c++)
        begin
            for (int i = 0; i < nb; i++)
                dif[i] = ($signed({32'd0, smp[i], 16'd0})) - 64'(class_words[c][i]);
            for (int i = 0; i < nb; i++)
            begin
                fwd[i] = dif[i];
                for (int j = 0; j < i; j++)
                    fwd[i] = add_sat(fwd[i],
                        -mul_q16(fwd[j], 64'(class_words[c][4 + i*4 + j])));
            end
            for (int i = nb - 1; i >= 0; i--)
            begin
                sol[i] = fwd[i];
                for (int j = nb - 1; j > i; j--)
                    sol[i] = add_sat(sol[i],
                        -mul_q16(sol[j], 64'(class_words[c][4 + i*4 + j])));
                sol[i] = div_q16(sol[i], 64'(class_words[c][4 + i*5]));
            end
            term = '0;
            for (int i = 0; i < nb; i++)
                term = add_sat(term, mul_q16(sol[i], dif[i]));
            if (limit_reg != LIMIT_ALL && term >= $signed({24'd0, limit_reg}))
                continue;
            score = add_sat(64'(class_words[c][E_OFFSET]), -(term / 2));
            if (!found || score > best)
            begin
                found = 1'b1;
                best = score;
                res.class_code = class_words[c][E_ID][15:0];
            end
        end
        res.status = found ? ST_CLASSIFIED : ST_NOCLASS;
        if (!found) res.class_code = noclass_reg;
        return res;
    endfunction

    // ---------------- transfer helpers ----------------
    // valid stays high between back-to-back items; idling and drain drop it
    task automatic send_item(in_item_t item);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        // transfer taken at this edge: predict it now
        if (item.cmd == CMD_LOAD)
        begin
            if (item.table_entry < ENTRIES)
                class_words[item.table_class][item.table_entry] = item.table_value;
        end
        else
            expected_codes.insert(expected_codes.size(), classify_pixel(item));
    endtask

    task automatic load_word(int cls, int ent, logic signed [31:0] val);
        in_item_t it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.table_class = 4'(cls);
        it.table_entry = 5'(ent);
        it.table_value = val;
        it.band_0 = 16'($urandom);
        it.band_3 = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_pixel(logic [15:0] b0, logic [15:0] b1,
                              logic [15:0] b2, logic [15:0] b3);
        in_item_t it;
        it = '0;
        it.cmd = CMD_CLASSIFY;
        it.table_class = 4'($urandom);
        it.table_entry = 5'($urandom);
        it.table_value = $urandom;
        it.band_0 = b0; it.band_1 = b1; it.band_2 = b2; it.band_3 = b3;
        send_item(it);
    endtask

    task automatic send_random_pixel();
        if ($urandom_range(0, 9) == 0)
            send_pixel(nodata_val_reg, nodata_val_reg, nodata_val_reg, nodata_val_reg);
        else
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // one write cycle, then cfg_write drops again before the task returns
    task automatic write_reg(logic [2:0] idx, logic [39:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_BANDS:        bands_reg = val[2:0];
            REG_CLASSES:      classes_reg = val[4:0];
            REG_LIMIT:        limit_reg = val;
            REG_NODATA_EN:    nodata_en_reg = val[0];
            REG_NODATA_VALUE: nodata_val_reg = val[15:0];
            REG_NOCLASS_CODE: noclass_reg = val[15:0];
            REG_NODATA_CODE:  nodata_code_reg = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // waits for all results, then idles on so no load is left in work
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // random but well-behaved class: mean near the sample range, LU with
    // a mix of small, large and occasionally zero pivots
    task automatic load_class(int cls);
        for (int e = 0; e < 4; e++)
            load_word(cls, e, $signed({1'b0, 15'($urandom), 16'($urandom)}));
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++)
            begin
                if (r == k)
                    case ($urandom_range(0, 19))
                        0: load_word(cls, 4 + r*4 + k, 32'sd0);
                        1: load_word(cls, 4 + r*4 + k, -$signed(32'($urandom_range(1, 32'h7FFF_FFFF))));
                        default: load_word(cls, 4 + r*4 + k,
                            $signed(32'($urandom_range(32'h1000, 32'h7FFF_FFFF))));
                    endcase
                else if ($urandom_range(0, 3) == 0)
                    load_word(cls, 4 + r*4 + k, 32'sd0);
                else
                    load_word(cls, 4 + r*4 + k, $signed(32'($urandom)) >>> $urandom_range(0, 14));
            end
        load_word(cls, E_OFFSET, $signed(32'($urandom)) >>> $urandom_range(0, 8));
        load_word(cls, E_ID, $signed(32'($urandom)));
    endtask

    // ---------------- result checking ----------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_codes.size() == 0)
            begin
                $error("result with nothing expected: class_code %0d status %0d",
                       out_data.class_code, out_data.status);
                error_count++;
            end
            else
            begin
                out_item_t exp_res;
                exp_res = expected_codes.pop_front();
                if (out_data.class_code !== exp_res.class_code)
                begin
                    $error("class_code expected %0d actual %0d",
                           exp_res.class_code, out_data.class_code);
                    error_count++;
                end
                if (out_data.status !== exp_res.status)
                begin
                    $error("status expected %0d actual %0d",
                           exp_res.status, out_data.status);
                    error_count++;
                end
            end
        end
    end

    // receiver: random idle bursts, or a long forced hold-off
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            out_ready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_gap <= $urandom_range(0, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ---------------- tests ----------------
    task automatic test_register_defaults();
        // untouched registers: 4 bands, one class, no limit, no nodata check
        load_class(0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();
    endtask

    task automatic test_directed_cases();
        for (int c = 1; c < NCLS; c++) load_class(c);
        // ties: identical slots 2 and 3 apart from id, lower slot must win
        for (int e = 0; e < ENTRIES - 1; e++)
            load_word(3, e, class_words[2][e]);
        load_word(3, E_ID, 32'sd999);
        drain();
        write_reg(REG_CLASSES, 5'd0);        // no class compared
        write_reg(REG_NOCLASS_CODE, 16'hFFFF);
        write_reg(REG_NODATA_CODE, 16'hABCD);
        write_reg(REG_NODATA_VALUE, 16'hFFFF);
        write_reg(REG_NODATA_EN, 1'b1);
        write_reg(REG_BANDS, 3'd0);          // acts as one band
        send_pixel(16'h1234, 16'h0, 16'h0, 16'h0);
        send_pixel(16'hFFFF, 16'h0, 16'h0, 16'h0);   // nodata on band 0 only
        drain();
        write_reg(REG_CLASSES, 5'd31);       // above the table size
        write_reg(REG_BANDS, 3'd7);
        write_reg(REG_LIMIT, 40'd0);         // only a negative term qualifies
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0); // not all nodata
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();
        write_reg(REG_LIMIT, 40'hFF_FFFF_FFFE);
        write_reg(REG_NODATA_EN, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0, 16'h0, 16'h0, 16'h0);
        drain();
        write_reg(REG_CLASSES, 5'd4);
        write_reg(REG_LIMIT, LIMIT_ALL);
        send_pixel(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE);
        // out-of-range entries must be ignored
        load_word(5, 22, 32'sh7FFF_FFFF);
        load_word(5, 31, -32'sh8000_0000);
        send_pixel(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00);
        drain();
    endtask

    task automatic run_random_phase(int pixels);
        for (int n = 0; n < pixels; n++)
        begin
            if ($urandom_range(0, 15) == 0)
                load_word($urandom_range(0, NCLS - 1), $urandom_range(0, 31),
                          $signed(32'($urandom)));
            send_random_pixel();
        end
        drain();
    endtask

    task automatic test_random_settings();
        logic [39:0] lim;
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_BANDS, 3'($urandom_range(0, 7)));
            write_reg(REG_CLASSES, 5'($urandom_range(1, 16)));
            case ($urandom_range(0, 3))
                0: lim = LIMIT_ALL;
                1: lim = 40'($urandom_range(0, 32'h00FF_FFFF));
                2: lim = {8'($urandom), 32'($urandom)};
                default: lim = 40'(32'($urandom));
            endcase
            write_reg(REG_LIMIT, lim);
            write_reg(REG_NODATA_EN, 1'($urandom));
            write_reg(REG_NODATA_VALUE, 16'($urandom));
            write_reg(REG_NOCLASS_CODE, 16'($urandom));
            write_reg(REG_NODATA_CODE, 16'($urandom));
            if (ph % 3 == 2) load_class($urandom_range(0, NCLS - 1));
            run_random_phase(40);
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_CLASSES, 5'd2);
        write_reg(REG_BANDS, 3'd2);
        rx_hold = 3000;
        for (int n = 0; n < 8; n++) send_random_pixel();
        drain();
    endtask

    task automatic test_no_idling();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_reg(REG_CLASSES, 5'd3);
        write_reg(REG_BANDS, 3'd4);
        run_random_phase(150);
    endtask

    initial
    begin
        for (int c = 0; c < NCLS; c++)
            for (int e = 0; e < ENTRIES; e++)
                class_words[c][e] = '0;
        bands_reg = 3'd4;
        classes_reg = 5'd1;
        limit_reg = LIMIT_ALL;
        nodata_en_reg = 1'b0;
        nodata_val_reg = '0;
        noclass_reg = '0;
        nodata_code_reg = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_defaults();
        test_directed_cases();
        test_backpressure();
        test_random_settings();
        test_no_idling();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("gaussian_max_likelihood_classifier verification clean");
        else
            $display("gaussian_max_likelihood_classifier verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("gaussian_max_likelihood_classifier verification failed");
        $finish;
    end

endmodule
